[design/fhn_pkg.sv]
// Package for the FitzHugh-Nagumo neuron update block.
// Holds the default sizes, command and register codes and the controller-to-datapath command types.
// Depends on nothing; fhn_dp, fhn_ctrl, the top level and the test files import it.
package fhn_pkg;

	localparam int DEF_NEURONS    = 1024;
	localparam int DEF_VALUE_BITS = 24;
	localparam int DEF_FRAC_BITS  = 18;

	localparam int CFG_BITS  = 24;
	localparam int CIDX_BITS = 3;
	localparam int IDX_BITS  = 10;
	localparam int REG_BITS  = 24;
	localparam int CNT_BITS  = 8;
	localparam int STEP_BITS = 19;

	// Item commands.
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_INIT   = 1'b1;

	// Register indexes on the configuration port.
	localparam logic [CIDX_BITS-1:0] REG_COEF_A     = 3'd0;
	localparam logic [CIDX_BITS-1:0] REG_COEF_B     = 3'd1;
	localparam logic [CIDX_BITS-1:0] REG_COEF_PHI   = 3'd2;
	localparam logic [CIDX_BITS-1:0] REG_STEP_COUNT = 3'd3;
	localparam logic [CIDX_BITS-1:0] REG_STEP_SIZE  = 3'd4;
	localparam logic [CIDX_BITS-1:0] REG_INIT_X     = 3'd5;
	localparam logic [CIDX_BITS-1:0] REG_INIT_W     = 3'd6;

	// Multiplier operand choice, driven by the controller.
	typedef enum logic [2:0] {
		MS_XX, MS_X2X, MS_X3T, MS_BW, MS_PHI, MS_DXH, MS_DWH
	} msel_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic  load;     // take x and w from the read data
		logic  mul_go;   // register a product
		msel_t msel;
		logic  cap_c3;   // capture dx, using x^3/3
		logic  cap_bw;   // capture b*w, form inner sum
		logic  cap_dw;   // capture dw
		logic  cap_nx;   // new x from dx*h
		logic  cap_nw;   // new w from dw*h
		logic  cap_out;  // fire test and result register
	} fhn_cmd_t;

endpackage

[design/fhn_ram.sv]
// Generic single-port RAM with a registered read.
// No dependencies.
module fhn_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and registered read; a read of the written address returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[design/fhn_dp.sv]
// Datapath of the neuron update: shared multiplier, adders, saturation, fire test.
// Depends on fhn_pkg.
module fhn_dp import fhn_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                         clk,
	input  fhn_cmd_t                     cmd,
	input  logic signed [VALUE_BITS-1:0] rd_x,
	input  logic signed [VALUE_BITS-1:0] rd_w,
	input  logic signed [VALUE_BITS-1:0] drive,
	input  logic signed [REG_BITS-1:0]   coef_a,
	input  logic signed [REG_BITS-1:0]   coef_b,
	input  logic signed [REG_BITS-1:0]   coef_phi,
	input  logic [STEP_BITS-1:0]         step_size,
	output logic signed [VALUE_BITS-1:0] x_out,
	output logic signed [VALUE_BITS-1:0] w_out,
	output logic                         fired
);
	localparam int V = VALUE_BITS;
	localparam int PW = 2 * V + 2;
	localparam int SW = V + 3;
	localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
	localparam logic signed [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};
	localparam logic signed [V+1:0] THIRD = (V+2)'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd3);
	localparam logic signed [V+1:0] ONE = (V+2)'(64'd1 << FRAC_BITS);

	function automatic logic signed [V-1:0] sat_s(input logic signed [SW-1:0] v);
		if (v > SW'(VMAX)) return VMAX;
		if (v < SW'(VMIN)) return VMIN;
		return v[V-1:0];
	endfunction

	logic signed [V-1:0] x_q, w_q, x2_q, x3_q, inner_q, dx_q, dw_q;
	logic signed [V:0] opa, opb;
	logic signed [PW-1:0] prod;
	logic [PW-1:0] mag;
	logic [PW-1:0] shq;
	logic signed [PW-1:0] lim;
	logic signed [V-1:0] mres;

	// Operand selection for the shared multiplier.
	always_comb begin
		opa = (V+1)'(x_q);
		opb = (V+1)'(x_q);
		case (cmd.msel)
			MS_XX:  begin opa = (V+1)'(x_q);  opb = (V+1)'(x_q); end
			MS_X2X: begin opa = (V+1)'(x2_q); opb = (V+1)'(x_q); end
			MS_X3T: begin opa = (V+1)'(x3_q); opb = (V+1)'(THIRD); end
			MS_BW:  begin opa = (V+1)'(coef_b); opb = (V+1)'(w_q); end
			MS_PHI: begin opa = (V+1)'(coef_phi); opb = (V+1)'(inner_q); end
			MS_DXH: begin opa = (V+1)'(dx_q); opb = $signed({1'b0, (V)'(step_size)}); end
			MS_DWH: begin opa = (V+1)'(dw_q); opb = $signed({1'b0, (V)'(step_size)}); end
			default: begin opa = (V+1)'(x_q); opb = (V+1)'(x_q); end
		endcase
	end

	// Product truncated toward zero and saturated.
	always_comb begin
		prod = PW'(opa) * PW'(opb);
		mag = prod[PW-1] ? PW'(-prod) : PW'(prod);
		shq = mag >> FRAC_BITS;
		if (prod[PW-1]) begin
			lim = -$signed(shq);
			mres = (shq > PW'(VMAX) + PW'(1)) ? VMIN : lim[V-1:0];
		end else begin
			lim = $signed(shq);
			mres = (shq > PW'(VMAX)) ? VMAX : lim[V-1:0];
		end
	end

	logic signed [V-1:0] dx_c, inner_c, nx_c, nw_c, h_c;

	// Sums, each saturated once.
	always_comb begin
		dx_c = sat_s(SW'(x_q) - SW'(mres) - SW'(w_q) + SW'(drive));
		inner_c = sat_s(SW'(x_q) + SW'(coef_a) - SW'(mres));
		nx_c = sat_s(SW'(x_q) + SW'(mres));
		nw_c = sat_s(SW'(w_q) + SW'(mres));
		h_c = sat_s(SW'(x_q) - SW'(mres));
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= rd_x;
			w_q <= rd_w;
		end
		if (cmd.mul_go && cmd.msel == MS_XX) x2_q <= mres;
		if (cmd.mul_go && cmd.msel == MS_X2X) x3_q <= mres;
		if (cmd.cap_c3) begin
			dx_q <= dx_c;
		end
		if (cmd.cap_bw) inner_q <= inner_c;
		if (cmd.cap_dw) dw_q <= mres;
		if (cmd.cap_nx) x_q <= nx_c;
		if (cmd.cap_nw) w_q <= nw_c;
		if (cmd.cap_out) begin
			fired <= (w_q > h_c) && (SW'(x_q) > SW'(ONE));
		end
	end

	assign x_out = x_q;
	assign w_out = w_q;
endmodule

[design/fhn_ctrl.sv]
// Controller of the neuron update: sequences memory access, Euler steps and result.
// Depends on fhn_pkg.
module fhn_ctrl import fhn_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_go,
	input  logic                in_init,
	input  logic [CNT_BITS-1:0] step_count,
	input  logic                out_free,
	output logic                busy,
	output logic                mem_we,
	output logic                out_load,
	output fhn_cmd_t            cmd
);
	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_LD = 4'd2, S_XX = 4'd3,
		S_X2X = 4'd4, S_X3T = 4'd5, S_BW = 4'd6, S_PHI = 4'd7, S_DXH = 4'd8,
		S_DWH = 4'd9, S_FX = 4'd10, S_FX2 = 4'd11, S_FT = 4'd12, S_OUT = 4'd13,
		S_INIT = 4'd14;

	logic [3:0] state_q, state_n;
	logic [CNT_BITS-1:0] left_q;
	logic fin_q;

	// Next state and commands.
	always_comb begin
		state_n = state_q;
		cmd = '0;
		cmd.msel = MS_XX;
		mem_we = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: if (in_go) state_n = in_init ? S_INIT : S_RD;
			S_INIT: begin mem_we = 1'b1; state_n = S_IDLE; end
			S_RD: state_n = S_LD;
			S_LD: begin
				cmd.load = 1'b1;
				state_n = (step_count == '0) ? S_FX : S_XX;
			end
			S_XX: begin cmd.mul_go = 1'b1; cmd.msel = MS_XX; state_n = S_X2X; end
			S_X2X: begin cmd.mul_go = 1'b1; cmd.msel = MS_X2X; state_n = S_X3T; end
			S_X3T: begin
				cmd.msel = MS_X3T; cmd.cap_c3 = 1'b1;
				state_n = fin_q ? S_FT : S_BW;
			end
			S_BW: begin cmd.msel = MS_BW; cmd.cap_bw = 1'b1; state_n = S_PHI; end
			S_PHI: begin cmd.msel = MS_PHI; cmd.cap_dw = 1'b1; state_n = S_DXH; end
			S_DXH: begin cmd.msel = MS_DXH; cmd.cap_nx = 1'b1; state_n = S_DWH; end
			S_DWH: begin
				cmd.msel = MS_DWH; cmd.cap_nw = 1'b1;
				state_n = (left_q <= CNT_BITS'(1)) ? S_FX : S_XX;
			end
			S_FX: begin cmd.mul_go = 1'b1; cmd.msel = MS_XX; state_n = S_FX2; end
			S_FX2: begin cmd.mul_go = 1'b1; cmd.msel = MS_X2X; state_n = S_X3T; end
			S_FT: begin cmd.msel = MS_X3T; cmd.cap_out = 1'b1; state_n = S_OUT; end
			S_OUT: if (out_free) begin
				out_load = 1'b1; mem_we = 1'b1; state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	// State, remaining steps and the final-test flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			left_q <= '0;
			fin_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_LD) left_q <= step_count;
			if (state_q == S_DWH) left_q <= left_q - CNT_BITS'(1);
			if (state_n == S_FX) fin_q <= 1'b1;
			if (state_q == S_IDLE) fin_q <= 1'b0;
		end
	end

	assign busy = (state_q != S_IDLE);

	am_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_INIT || state_q == S_OUT))
		else $error("memory write outside init or result");
	am_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> state_q == S_IDLE)
		else $error("result load not followed by idle");
	am_test_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FT) |-> fin_q)
		else $error("fire test outside the final pass");
endmodule

[design/fitzhugh_nagumo_neuron_update.sv]
// FitzHugh-Nagumo neuron update, top level: stream ports, registers, memories.
// Depends on fhn_pkg, fhn_ram, fhn_ctrl and fhn_dp.
// One item at a time: a new item is taken only while the controller is idle, and an
// update item also waits for the output register to be free. The shared multiplier,
// used seven times per Euler step, sets how long an update takes. Memories are not cleared.
module fitzhugh_nagumo_neuron_update import fhn_pkg::*; #(
	parameter int NEURONS    = DEF_NEURONS,
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [39:0]          s_tdata,  // cmd, neuron_index, syn_input, disabled
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [63:0]          m_tdata,  // out_index, fired, x_value, w_value
	input  logic                 cfg_we,
	input  logic [CIDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]  cfg_data
);
	localparam int AW = $clog2(NEURONS);

	logic signed [REG_BITS-1:0] a_q, b_q, phi_q, ix_q, iw_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [STEP_BITS-1:0] h_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 24'sd183500; b_q <= 24'sd209715; phi_q <= 24'sd20972;
			cnt_q <= 8'd1; h_q <= 19'd262144; ix_q <= '0; iw_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_A:     a_q <= cfg_data;
				REG_COEF_B:     b_q <= cfg_data;
				REG_COEF_PHI:   phi_q <= cfg_data;
				REG_STEP_COUNT: cnt_q <= cfg_data[CNT_BITS-1:0];
				REG_STEP_SIZE:  h_q <= cfg_data[STEP_BITS-1:0];
				REG_INIT_X:     ix_q <= cfg_data;
				REG_INIT_W:     iw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic busy, mem_we, out_load, out_free, in_go, acc;
	fhn_cmd_t cmd;
	logic init_q;
	logic [IDX_BITS-1:0] idx_q;
	logic signed [VALUE_BITS-1:0] drive_q, rx, rw, xo, wo, wx, ww;
	logic fired;

	assign s_tready = !busy;
	assign acc = s_tvalid && s_tready;
	assign in_go = acc && !s_tdata[35] && (32'(s_tdata[10:1]) < NEURONS);
	assign out_free = !m_tvalid || m_tready;

	// Captured item fields.
	always_ff @(posedge clk) begin
		if (acc) begin
			init_q <= s_tdata[0];
			idx_q <= s_tdata[10:1];
			drive_q <= VALUE_BITS'($signed(s_tdata[34:11]));
		end
	end

	assign wx = init_q ? VALUE_BITS'(ix_q) : xo;
	assign ww = init_q ? VALUE_BITS'(iw_q) : wo;

	fhn_ram #(.WIDTH(VALUE_BITS), .DEPTH(NEURONS)) u_xmem (
		.clk(clk), .we(mem_we), .addr(idx_q[AW-1:0]), .wdata(wx), .rdata(rx));
	fhn_ram #(.WIDTH(VALUE_BITS), .DEPTH(NEURONS)) u_wmem (
		.clk(clk), .we(mem_we), .addr(idx_q[AW-1:0]), .wdata(ww), .rdata(rw));

	fhn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .in_init(s_tdata[0] == CMD_INIT),
		.step_count(cnt_q), .out_free(out_free), .busy(busy), .mem_we(mem_we),
		.out_load(out_load), .cmd(cmd));

	fhn_dp #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .cmd(cmd), .rd_x(rx), .rd_w(rw), .drive(drive_q),
		.coef_a(a_q), .coef_b(b_q), .coef_phi(phi_q), .step_size(h_q),
		.x_out(xo), .w_out(wo), .fired(fired));

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {5'd0, 24'(wo), 24'(xo), fired, idx_q};
		end
	end
endmodule

[test/fhn_checker.sv]
// Checker for the FitzHugh-Nagumo neuron update block: watches the stream and register ports.
// Keeps its own copy of the registers and neuron stores and predicts each result item.
// Depends on fhn_pkg for the register and command codes.
module fhn_checker import fhn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [39:0]          s_tdata,  // cmd, neuron_index, syn_input, disabled
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [63:0]          m_tdata,  // out_index, fired, x_value, w_value
	input  logic                 cfg_we,
	input  logic [CIDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]  cfg_data,
	output int                   fail_count,
	output int                   outstanding,
	output int                   result_count,
	output int                   fired_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint VMAX  = (longint'(1) <<< 23) - 1;
	localparam longint VMIN  = -VMAX - 1;
	localparam longint ONE   = longint'(1) <<< 18;
	localparam longint THIRD = ((longint'(1) <<< 18) + 1) / 3;

	typedef struct {
		logic [9:0]         index;
		logic               fired;
		logic signed [23:0] x;
		logic signed [23:0] w;
	} neuron_result_t;

	neuron_result_t result_queue[$];

	longint a_coef, b_coef, phi_coef, x_init, w_init;
	longint n_steps, h_step;
	longint membrane[1024];
	longint recovery[1024];

	function automatic longint sat(longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	// Product with the magnitude truncated towards zero, then saturated.
	function automatic longint fx_mul(longint p, longint q);
		logic   neg;
		longint mag;
		longint lim;
		neg = (p < 0) != (q < 0);
		mag = ((p < 0) ? -p : p) * ((q < 0) ? -q : q);
		mag = mag >>> 18;
		lim = neg ? VMAX + 1 : VMAX;
		if (mag > lim)
			mag = lim;
		return neg ? -mag : mag;
	endfunction

	function automatic longint cubic_third(longint x);
		return fx_mul(fx_mul(fx_mul(x, x), x), THIRD);
	endfunction

	// Runs the Euler steps for one neuron and queues the result it should give.
	task automatic integrate_neuron(input logic [9:0] idx, input longint drive);
		longint         x;
		longint         w;
		longint         dx;
		longint         dw;
		neuron_result_t r;
		x = membrane[idx];
		w = recovery[idx];
		for (longint k = 0; k < n_steps; k++) begin
			dx = sat(x - cubic_third(x) - w + drive);
			dw = fx_mul(phi_coef, sat(x + a_coef - fx_mul(b_coef, w)));
			x  = sat(x + fx_mul(dx, h_step));
			w  = sat(w + fx_mul(dw, h_step));
		end
		membrane[idx] = x;
		recovery[idx] = w;
		r.index = idx;
		r.fired = (w > sat(x - cubic_third(x))) && (x > ONE);
		r.x     = x[23:0];
		r.w     = w[23:0];
		result_queue.push_back(r);
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Register mirror, prediction on each accepted item, comparison on each result item.
	always @(posedge clk or negedge arst_n) begin
		logic               item_cmd;
		logic [9:0]         item_idx;
		logic signed [23:0] item_drive;
		logic               item_off;
		neuron_result_t     want;
		if (!arst_n) begin
			a_coef   = 183500;
			b_coef   = 209715;
			phi_coef = 20972;
			n_steps  = 1;
			h_step   = 262144;
			x_init   = 0;
			w_init   = 0;
			fail_count   = 0;
			result_count = 0;
			fired_count  = 0;
			result_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COEF_A:     a_coef   = longint'($signed(cfg_data));
					REG_COEF_B:     b_coef   = longint'($signed(cfg_data));
					REG_COEF_PHI:   phi_coef = longint'($signed(cfg_data));
					REG_STEP_COUNT: n_steps  = longint'(cfg_data[CNT_BITS-1:0]);
					REG_STEP_SIZE:  h_step   = longint'(cfg_data[STEP_BITS-1:0]);
					REG_INIT_X:     x_init   = longint'($signed(cfg_data));
					REG_INIT_W:     w_init   = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				item_cmd   = s_tdata[0];
				item_idx   = s_tdata[10:1];
				item_drive = s_tdata[34:11];
				item_off   = s_tdata[35];
				if (!item_off) begin
					if (item_cmd == CMD_INIT) begin
						membrane[item_idx] = sat(x_init);
						recovery[item_idx] = sat(w_init);
					end else begin
						integrate_neuron(item_idx, longint'(item_drive));
					end
				end
			end
			if (m_tvalid && m_tready) begin
				if (result_queue.size() == 0) begin
					$display("%0t: result item with none expected, neuron %0d",
						$realtime, m_tdata[9:0]);
					fail_count++;
				end else begin
					want = result_queue.pop_front();
					result_count++;
					if (want.fired)
						fired_count++;
					if (m_tdata[9:0] !== want.index)
						report("out_index", m_tdata[9:0], want.index);
					if (m_tdata[10] !== want.fired)
						report("fired", m_tdata[10], want.fired);
					if (m_tdata[34:11] !== want.x)
						report("x_value", $signed(m_tdata[34:11]), want.x);
					if (m_tdata[58:35] !== want.w)
						report("w_value", $signed(m_tdata[58:35]), want.w);
				end
			end
		end
		outstanding = result_queue.size();
	end

endmodule

[test/fitzhugh_nagumo_neuron_update_tb.sv]
// Testbench top for the FitzHugh-Nagumo neuron update block: clock, reset, stimulus, verdict.
// Depends on fhn_pkg, the block itself and fhn_checker, which does all prediction and checking.
module fitzhugh_nagumo_neuron_update_tb;
	import fhn_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [39:0]          s_tdata = '0;  // cmd, neuron_index, syn_input, disabled
	logic                 m_tready = 1'b0;
	logic                 m_tvalid;
	logic [63:0]          m_tdata;       // out_index, fired, x_value, w_value
	logic                 cfg_we = 1'b0;
	logic [CIDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0]  cfg_data = '0;

	int  fail_count, outstanding, result_count, fired_count;
	int  idle_cycles = 0;
	int  rx_stall = 0;
	bit  calm = 1'b0;
	bit  ready_set[1024];
	int  update_count = 0;
	int  init_count = 0;
	int  phase_count = 0;

	fitzhugh_nagumo_neuron_update u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	fhn_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .outstanding(outstanding),
		.result_count(result_count), .fired_count(fired_count)
	);

	always #5 clk = ~clk;

	// Gap lengths: mostly none or short, now and then long.
	function automatic int pick_gap();
		if (calm || $urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver side stalls.
	always @(posedge clk) begin
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else begin
			m_tready <= 1'b1;
			rx_stall <= pick_gap();
		end
	end

	// Watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", idle_cycles);
			$display("fitzhugh_nagumo_neuron_update test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic cmd, input logic [9:0] idx,
			input logic [23:0] drive, input logic off);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, off, drive, idx, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (!off) begin
			if (cmd == CMD_INIT) begin
				ready_set[idx] = 1'b1;
				init_count++;
			end else begin
				update_count++;
			end
		end
	endtask

	// Holds the sender until every expected result item has arrived and the block is quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Drives one register write; the caller drops the write enable after the last one.
	task automatic write_reg(input logic [CIDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	function automatic logic [23:0] pick_drive();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 24'($signed($urandom_range(0, 1048576)) - 524288);
			2: return ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
			default: return 24'($signed($urandom_range(0, 262144)) - 65536);
		endcase
	endfunction

	// Random items: mostly updates of initialised neurons, some initialisations and noise.
	task automatic random_items(input int count);
		int          sel;
		logic [9:0]  idx;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			idx = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 15)) : 10'($urandom());
			if (sel < 10) begin
				send_item(1'($urandom()), 10'($urandom()), 24'($urandom()), 1'b1);
			end else if (sel < 25 || !ready_set[idx]) begin
				send_item(CMD_INIT, idx, 24'($urandom()), 1'b0);
			end else begin
				send_item(CMD_UPDATE, idx, pick_drive(), 1'b0);
			end
		end
	endtask

	task automatic run_phase(input int a, input int b, input int phi, input int steps,
			input int h, input int ix, input int iw, input int count);
		drain();
		write_reg(REG_COEF_A, 24'(a));
		write_reg(REG_COEF_B, 24'(b));
		write_reg(REG_COEF_PHI, 24'(phi));
		write_reg(REG_STEP_COUNT, 24'(steps));
		write_reg(REG_STEP_SIZE, 24'(h));
		write_reg(REG_INIT_X, 24'(ix));
		write_reg(REG_INIT_W, 24'(iw));
		cfg_we <= 1'b0;
		calm = ($urandom_range(0, 3) == 0);
		phase_count++;
		random_items(count);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset settings.
		send_item(CMD_INIT, 10'd0, 24'd0, 1'b0);
		send_item(CMD_INIT, 10'd1023, 24'h7FFFFF, 1'b0);
		send_item(CMD_UPDATE, 10'd0, 24'h7FFFFF, 1'b0);
		send_item(CMD_UPDATE, 10'd0, 24'h800000, 1'b0);
		send_item(CMD_UPDATE, 10'd1023, 24'd0, 1'b0);
		send_item(CMD_UPDATE, 10'd5, 24'h123456, 1'b1);
		send_item(CMD_INIT, 10'd7, 24'd0, 1'b1);
		send_item(CMD_INIT, 10'd7, 24'hFFFFFF, 1'b0);
		send_item(CMD_UPDATE, 10'd7, 24'd262144, 1'b0);
		send_item(CMD_UPDATE, 10'd7, 24'd262144, 1'b1);
		for (int n = 0; n < 6; n++)
			send_item(CMD_UPDATE, 10'd7, 24'd393216, 1'b0);
		send_item(CMD_UPDATE, 10'd1023, 24'hFFFFFF, 1'b0);

		// Settings sweep, extremes included; the slow 255-step phase is kept short.
		run_phase(183500, 209715, 20972, 8, 32768, -314572, -163840, 380);
		run_phase(8388607, -8388608, 8388607, 1, 262144, 8388607, -8388608, 150);
		run_phase(-8388608, 8388607, -8388608, 0, 0, -8388608, 8388607, 100);
		run_phase(183500, 209715, 20972, 255, 1028, 0, 0, 12);
		run_phase(183500, 209715, 20972, 4, 65536, 262144, 0, 400);
		run_phase(0, 0, 0, 2, 131072, 524288, -262144, 120);
		run_phase(183500, 209715, 20972, 1, 524287, -8388608, 8388607, 60);

		drain();
		$display("%0d phases: %0d updates, %0d initialisations, %0d results (%0d fired)",
			phase_count, update_count, init_count, result_count, fired_count);
		if (fail_count == 0) begin
			$display("fitzhugh_nagumo_neuron_update test passed");
		end else begin
			$display("fitzhugh_nagumo_neuron_update test failed");
		end
		$finish;
	end

endmodule

[filelist.f]
design/fhn_pkg.sv
design/fhn_ram.sv
design/fhn_dp.sv
design/fhn_ctrl.sv
design/fitzhugh_nagumo_neuron_update.sv
test/fhn_checker.sv
test/fitzhugh_nagumo_neuron_update_tb.sv
